// ===== rtl/tsrl_pkg.sv =====
// ----------------------------------------------------------------------------
// tsrl_pkg
// Shared types and constants of the teleoperation slew-rate limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package tsrl_pkg;

   // Register widths
   localparam int MAG_W     = 15;
   localparam int TICKS_W   = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 15;
   localparam int KEY_W     = 8;
   localparam int OUT_W     = 16;

   // Register reset values (Q3.12 where a speed)
   localparam logic [MAG_W-1:0]   MAX_LINEAR_RST    = 15'd4997;
   localparam logic [MAG_W-1:0]   MAX_ANGULAR_RST   = 15'd2458;
   localparam logic [MAG_W-1:0]   LINEAR_STEP_RST   = 15'd102;
   localparam logic [MAG_W-1:0]   ANGULAR_STEP_RST  = 15'd307;
   localparam logic [TICKS_W-1:0] TIMEOUT_TICKS_RST = 8'd3;

   // Saturation point of the tick counter
   localparam logic [TICKS_W-1:0] TICKS_SAT = 8'd255;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_LINEAR    = 3'd0,
      CSR_MAX_ANGULAR   = 3'd1,
      CSR_LINEAR_STEP   = 3'd2,
      CSR_ANGULAR_STEP  = 3'd3,
      CSR_TIMEOUT_TICKS = 3'd4
   } csr_index_type;

   // Request kinds
   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_KEY  = 1'b1;

   // Key codes (ASCII)
   localparam logic [KEY_W-1:0] KEY_W_LO = 8'h77;
   localparam logic [KEY_W-1:0] KEY_W_UP = 8'h57;
   localparam logic [KEY_W-1:0] KEY_S_LO = 8'h73;
   localparam logic [KEY_W-1:0] KEY_S_UP = 8'h53;
   localparam logic [KEY_W-1:0] KEY_A_LO = 8'h61;
   localparam logic [KEY_W-1:0] KEY_A_UP = 8'h41;
   localparam logic [KEY_W-1:0] KEY_D_LO = 8'h64;
   localparam logic [KEY_W-1:0] KEY_D_UP = 8'h44;
   localparam logic [KEY_W-1:0] KEY_SPACE = 8'h20;

   // Configuration set handed to the update logic
   typedef struct packed {
      logic [MAG_W-1:0]   max_linear;
      logic [MAG_W-1:0]   max_angular;
      logic [MAG_W-1:0]   linear_step;
      logic [MAG_W-1:0]   angular_step;
      logic [TICKS_W-1:0] timeout_ticks;
   } cfg_type;

endpackage

`default_nettype wire

// ===== rtl/tsrl_if.sv =====
// ----------------------------------------------------------------------------
// tsrl_if
// Request and response channel interfaces (valid/ready handshake).
// ----------------------------------------------------------------------------
`default_nettype none

interface tsrl_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] key_code;

   modport source (output valid, output func, output key_code, input ready);
   modport sink (input valid, input func, input key_code, output ready);
endinterface

interface tsrl_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] linear_velocity;
   logic signed [15:0] angular_velocity;

   modport source (output valid, output linear_velocity, output angular_velocity,
                   input ready);
   modport sink (input valid, input linear_velocity, input angular_velocity,
                 output ready);
endinterface

`default_nettype wire

// ===== rtl/tsrl_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tsrl_cfg_regs
// Write-only configuration registers; unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module tsrl_cfg_regs
   import tsrl_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_wdata,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write and mask the data to the register width
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_MAX_LINEAR:    cfg_in.max_linear    = csr_wdata[MAG_W-1:0];
            CSR_MAX_ANGULAR:   cfg_in.max_angular   = csr_wdata[MAG_W-1:0];
            CSR_LINEAR_STEP:   cfg_in.linear_step   = csr_wdata[MAG_W-1:0];
            CSR_ANGULAR_STEP:  cfg_in.angular_step  = csr_wdata[MAG_W-1:0];
            CSR_TIMEOUT_TICKS: cfg_in.timeout_ticks = csr_wdata[TICKS_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_linear    <= MAX_LINEAR_RST;
         cfg_ff.max_angular   <= MAX_ANGULAR_RST;
         cfg_ff.linear_step   <= LINEAR_STEP_RST;
         cfg_ff.angular_step  <= ANGULAR_STEP_RST;
         cfg_ff.timeout_ticks <= TIMEOUT_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/tsrl_update.sv =====
// ----------------------------------------------------------------------------
// tsrl_update
// Target, current-value and tick-counter state with the per-request update:
// key decode, dead-man timeout, slew toward target and output saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module tsrl_update
   import tsrl_pkg::*;
#(
   parameter int VELOCITY_BITS = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    advance,
   input  wire logic                    func,
   input  wire logic [KEY_W-1:0]        key_code,
   input  wire cfg_type                 cfg,
   output logic signed [OUT_W-1:0]      linear_out,
   output logic signed [OUT_W-1:0]      angular_out
);

   // Working width: holds any velocity, any step and their sum
   localparam int EW = ((VELOCITY_BITS > OUT_W) ? VELOCITY_BITS : OUT_W) + 2;
   localparam logic signed [EW-1:0] VEL_HI =
      EW'((longint'(1) << (VELOCITY_BITS - 1)) - longint'(1));
   localparam logic signed [EW-1:0] VEL_LO = -VEL_HI - EW'(1);
   localparam logic signed [EW-1:0] OUT_HI =
      EW'((longint'(1) << (OUT_W - 1)) - longint'(1));
   localparam logic signed [EW-1:0] OUT_LO = -OUT_HI - EW'(1);

   logic signed [VELOCITY_BITS-1:0] lin_tgt_ff, lin_tgt_in;
   logic signed [VELOCITY_BITS-1:0] ang_tgt_ff, ang_tgt_in;
   logic signed [VELOCITY_BITS-1:0] lin_cur_ff, lin_cur_in;
   logic signed [VELOCITY_BITS-1:0] ang_cur_ff, ang_cur_in;
   logic [TICKS_W-1:0]              ticks_ff, ticks_in;

   logic signed [EW-1:0] max_lin_ext;
   logic signed [EW-1:0] max_ang_ext;
   logic [TICKS_W-1:0]   ticks_inc;

   // Saturate a working value to the velocity range
   function automatic logic signed [VELOCITY_BITS-1:0] sat_vel(
      input logic signed [EW-1:0] v);
      logic signed [EW-1:0] r;
      r = v;
      if (v > VEL_HI) r = VEL_HI;
      if (v < VEL_LO) r = VEL_LO;
      return r[VELOCITY_BITS-1:0];
   endfunction

   // Move toward target by at most step, never past it
   function automatic logic signed [VELOCITY_BITS-1:0] slew(
      input logic signed [VELOCITY_BITS-1:0] cur,
      input logic signed [VELOCITY_BITS-1:0] tgt,
      input logic [MAG_W-1:0]                step);
      logic signed [EW-1:0] c;
      logic signed [EW-1:0] t;
      logic signed [EW-1:0] s;
      logic signed [EW-1:0] r;
      c = EW'(cur);
      t = EW'(tgt);
      s = EW'($signed({1'b0, step}));
      r = c;
      if (c < t) r = ((c + s) < t) ? (c + s) : t;
      if (c > t) r = ((c - s) > t) ? (c - s) : t;
      return r[VELOCITY_BITS-1:0];
   endfunction

   // Clamp a velocity to the 16-bit result range
   function automatic logic signed [OUT_W-1:0] to_out(
      input logic signed [VELOCITY_BITS-1:0] v);
      logic signed [EW-1:0] r;
      r = EW'(v);
      if (r > OUT_HI) r = OUT_HI;
      if (r < OUT_LO) r = OUT_LO;
      return r[OUT_W-1:0];
   endfunction

   assign max_lin_ext = EW'($signed({1'b0, cfg.max_linear}));
   assign max_ang_ext = EW'($signed({1'b0, cfg.max_angular}));
   assign ticks_inc   = (ticks_ff < TICKS_SAT) ? (ticks_ff + TICKS_W'(1)) : ticks_ff;

   // Work out the next state for the request leaving the input register
   always_comb begin
      lin_tgt_in = lin_tgt_ff;
      ang_tgt_in = ang_tgt_ff;
      lin_cur_in = lin_cur_ff;
      ang_cur_in = ang_cur_ff;
      ticks_in   = ticks_ff;
      if (func == FUNC_KEY) begin
         ticks_in = '0;
         case (key_code)
            KEY_W_LO, KEY_W_UP: lin_tgt_in = sat_vel(max_lin_ext);
            KEY_S_LO, KEY_S_UP: lin_tgt_in = sat_vel(-max_lin_ext);
            KEY_A_LO, KEY_A_UP: ang_tgt_in = sat_vel(max_ang_ext);
            KEY_D_LO, KEY_D_UP: ang_tgt_in = sat_vel(-max_ang_ext);
            KEY_SPACE: begin
               lin_tgt_in = '0;
               ang_tgt_in = '0;
               lin_cur_in = '0;
               ang_cur_in = '0;
            end
            default: ticks_in = '0;
         endcase
      end else begin
         ticks_in = ticks_inc;
         if (ticks_inc > cfg.timeout_ticks) begin
            lin_tgt_in = '0;
            ang_tgt_in = '0;
         end
         lin_cur_in = slew(lin_cur_ff, lin_tgt_in, cfg.linear_step);
         ang_cur_in = slew(ang_cur_ff, ang_tgt_in, cfg.angular_step);
      end
   end

   // Commit the state only when a request advances
   always_ff @(posedge clock) begin
      if (reset) begin
         lin_tgt_ff <= '0;
         ang_tgt_ff <= '0;
         lin_cur_ff <= '0;
         ang_cur_ff <= '0;
         ticks_ff   <= '0;
      end else if (advance) begin
         lin_tgt_ff <= lin_tgt_in;
         ang_tgt_ff <= ang_tgt_in;
         lin_cur_ff <= lin_cur_in;
         ang_cur_ff <= ang_cur_in;
         ticks_ff   <= ticks_in;
      end
   end

   assign linear_out  = to_out(lin_cur_in);
   assign angular_out = to_out(ang_cur_in);

endmodule

`default_nettype wire

// ===== rtl/teleop_slew_rate_limiter.sv =====
// ----------------------------------------------------------------------------
// teleop_slew_rate_limiter
// Key and tick driven two-axis velocity command with slew limiting and a
// dead-man timeout.
//
// Channels: req_ch carries one request per event, func = 0 for a control
// tick and 1 for a key press with its ASCII key_code. rsp_ch returns one
// linear/angular pair (signed Q3.12) for every tick and nothing for a key.
// csr_write_en/csr_index/csr_wdata write the five limit registers; write
// them only while no request is in flight.
// A tick in the input register moves to the response register once the
// response slot is free. Throughput: one request per cycle while responses
// are taken, set by the single input register feeding the update logic.
// Reset: limits return to their defaults, targets, current values and the
// tick counter clear, both channels empty; req_ch.ready stays low in reset.
// Stall: a held response keeps its data; the input register still drains
// key presses, and ticks wait behind it, so req_ch.ready drops once a tick
// sits in the input register behind an untaken response.
// ----------------------------------------------------------------------------
`default_nettype none

module teleop_slew_rate_limiter
   import tsrl_pkg::*;
#(
   parameter int VELOCITY_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   tsrl_req_if.sink                  req_ch,
   tsrl_rsp_if.source                rsp_ch,
   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_wdata
);

   cfg_type cfg;

   logic             req_valid_ff, req_valid_in;
   logic             req_func_ff;
   logic [KEY_W-1:0] req_key_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0] rsp_lin_ff;
   logic signed [OUT_W-1:0] rsp_ang_ff;
   logic signed [OUT_W-1:0] lin_next;
   logic signed [OUT_W-1:0] ang_next;

   logic out_free;
   logic advance;
   logic accept;
   logic load_rsp;

   tsrl_cfg_regs u_cfg (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   tsrl_update #(
      .VELOCITY_BITS (VELOCITY_BITS)
   ) u_update (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .func        (req_func_ff),
      .key_code    (req_key_ff),
      .cfg         (cfg),
      .linear_out  (lin_next),
      .angular_out (ang_next)
   );

   // Handshake control: keys always drain, ticks need a free response slot
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign advance      = req_valid_ff && ((req_func_ff == FUNC_KEY) || out_free);
   assign req_ch.ready = !reset && (!req_valid_ff || advance);
   assign accept       = req_ch.valid && req_ch.ready;
   assign load_rsp     = advance && (req_func_ff == FUNC_TICK);

   assign req_valid_in = accept || (req_valid_ff && !advance);
   assign rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_ch.ready);

   // Hold the accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_func_ff <= req_ch.func;
         req_key_ff  <= req_ch.key_code;
      end
   end

   // Register the response
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_lin_ff <= lin_next;
         rsp_ang_ff <= ang_next;
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.linear_velocity  = rsp_lin_ff;
   assign rsp_ch.angular_velocity = rsp_ang_ff;

endmodule

`default_nettype wire

// ===== rtl/tsrl_checker.sv =====
// ----------------------------------------------------------------------------
// tsrl_checker
// Port-level checks of the slew-rate limiter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tsrl_checker
   import tsrl_pkg::*;
(
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_valid,
   input wire logic                    req_ready,
   input wire logic                    req_func,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire logic signed [OUT_W-1:0] rsp_linear,
   input wire logic signed [OUT_W-1:0] rsp_angular
);

   // Reset empties the response channel
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A fresh response comes from a tick accepted through the input register
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && (req_func == FUNC_TICK), 2))
      else $error("response without a preceding tick");

   // Targets never go below minus the largest magnitude, so neither is the output
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_linear != 16'sh8000) && (rsp_angular != 16'sh8000))
      else $error("response at most-negative code");

   // A stalled response holds its data
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_linear) && $stable(rsp_angular))
      else $error("stalled response changed");

endmodule

bind teleop_slew_rate_limiter tsrl_checker u_tsrl_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .req_func    (req_ch.func),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_linear  (rsp_ch.linear_velocity),
   .rsp_angular (rsp_ch.angular_velocity)
);

`default_nettype wire

// ===== verif/tb_teleop_slew_rate_limiter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_teleop_slew_rate_limiter
// Drives key presses and control ticks into the slew-rate limiter and checks
// every velocity pair against a cycle-free model of the targets, the current
// values and the dead-man tick counter. Limit registers are rewritten between
// phases while the block is idle. Both channels idle at random, and the
// response side holds off once for a long stretch.
// ----------------------------------------------------------------------------

module tb_teleop_slew_rate_limiter;
   import tsrl_pkg::*;

   localparam int VEL_BITS      = 16;
   localparam int CLOCK_HALF    = 6;
   localparam int RESET_CYCLES  = 5;
   localparam int SETTLE_CYCLES = 4;
   localparam int LONG_HOLD     = 300;
   localparam int PRESSURE_TICKS = 40;
   localparam int IDLE_LIMIT    = 2000;
   localparam int REPORT_LIMIT  = 10;
   localparam int PHASE_COUNT   = 7;
   localparam int PHASE_ITEMS   = 160;
   localparam int SAT_TICKS     = 300;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_FIRST = 3'd5;

   typedef struct {
      logic signed [OUT_W-1:0] linear;
      logic signed [OUT_W-1:0] angular;
   } velocity_pair_type;

   // Model of the limiter and the queue of velocity pairs still owed
   class velocity_scoreboard;
      cfg_type              limits;
      longint               lin_target, ang_target, lin_now, ang_now;
      logic [TICKS_W-1:0]   quiet_ticks;
      velocity_pair_type    commands_due[$];
      int                   failures;

      function new();
         failures = 0;
         limits.max_linear    = MAX_LINEAR_RST;
         limits.max_angular   = MAX_ANGULAR_RST;
         limits.linear_step   = LINEAR_STEP_RST;
         limits.angular_step  = ANGULAR_STEP_RST;
         limits.timeout_ticks = TIMEOUT_TICKS_RST;
         lin_target  = 0;
         ang_target  = 0;
         lin_now     = 0;
         ang_now     = 0;
         quiet_ticks = '0;
      endfunction

      function void flag_failure(string msg);
         failures++;
         if (failures <= REPORT_LIMIT) begin
            $display("%0t ns: mismatch: %s", $time, msg);
         end
      endfunction

      // Spare indexes are dropped, data is cut to the register width
      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] data);
         case (idx)
            CSR_MAX_LINEAR:    limits.max_linear    = data[MAG_W-1:0];
            CSR_MAX_ANGULAR:   limits.max_angular   = data[MAG_W-1:0];
            CSR_LINEAR_STEP:   limits.linear_step   = data[MAG_W-1:0];
            CSR_ANGULAR_STEP:  limits.angular_step  = data[MAG_W-1:0];
            CSR_TIMEOUT_TICKS: limits.timeout_ticks = data[TICKS_W-1:0];
            default: ;
         endcase
      endfunction

      // Saturate a target to the signed range of the velocity width
      function longint fit_velocity(longint v);
         longint hi;
         hi = (longint'(1) <<< (VEL_BITS - 1)) - 1;
         if (v > hi) return hi;
         if (v < -hi - 1) return -hi - 1;
         return v;
      endfunction

      // Move toward the target by at most one step, never past it
      function longint slew_toward(longint cur, longint tgt, longint step);
         if (cur < tgt) return (cur + step < tgt) ? cur + step : tgt;
         if (cur > tgt) return (cur - step > tgt) ? cur - step : tgt;
         return cur;
      endfunction

      function logic signed [OUT_W-1:0] to_output(longint v);
         longint hi;
         hi = (longint'(1) <<< (OUT_W - 1)) - 1;
         if (v > hi) v = hi;
         if (v < -hi - 1) v = -hi - 1;
         return v[OUT_W-1:0];
      endfunction

      // Advance the model by one accepted request
      function void note_request(logic func, logic [KEY_W-1:0] key);
         velocity_pair_type cmd;
         if (func == FUNC_KEY) begin
            quiet_ticks = '0;
            case (key)
               KEY_W_LO, KEY_W_UP: lin_target = fit_velocity(longint'(limits.max_linear));
               KEY_S_LO, KEY_S_UP: lin_target = fit_velocity(-longint'(limits.max_linear));
               KEY_A_LO, KEY_A_UP: ang_target = fit_velocity(longint'(limits.max_angular));
               KEY_D_LO, KEY_D_UP: ang_target = fit_velocity(-longint'(limits.max_angular));
               KEY_SPACE: begin
                  lin_target = 0;
                  ang_target = 0;
                  lin_now    = 0;
                  ang_now    = 0;
               end
               default: ;
            endcase
         end else begin
            if (quiet_ticks != TICKS_SAT) quiet_ticks++;
            // Dead-man timeout: drop both targets
            if (quiet_ticks > limits.timeout_ticks) begin
               lin_target = 0;
               ang_target = 0;
            end
            lin_now = slew_toward(lin_now, lin_target, longint'(limits.linear_step));
            ang_now = slew_toward(ang_now, ang_target, longint'(limits.angular_step));
            cmd.linear  = to_output(lin_now);
            cmd.angular = to_output(ang_now);
            commands_due.push_back(cmd);
         end
      endfunction

      // Compare a response with the oldest owed pair
      function void check_response(logic signed [OUT_W-1:0] lin, logic signed [OUT_W-1:0] ang);
         velocity_pair_type cmd;
         if (commands_due.size() == 0) begin
            flag_failure($sformatf("response %0d/%0d with nothing owed", lin, ang));
            return;
         end
         cmd = commands_due.pop_front();
         if (lin !== cmd.linear) begin
            flag_failure($sformatf("linear expected %0d got %0d", cmd.linear, lin));
         end
         if (ang !== cmd.angular) begin
            flag_failure($sformatf("angular expected %0d got %0d", cmd.angular, ang));
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   tsrl_req_if req_bus();
   tsrl_rsp_if rsp_bus();

   velocity_scoreboard sb;
   bit  gaps_on;
   int  hold_requests;
   int  hold_served;
   int  stall_left;
   int  idle_cycles;
   int  key_pct;

   teleop_slew_rate_limiter #(
      .VELOCITY_BITS (VEL_BITS)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_bus),
      .rsp_ch       (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!gaps_on || roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [KEY_W-1:0] motion_key();
      case ($urandom_range(0, 7))
         0: return KEY_W_LO;
         1: return KEY_W_UP;
         2: return KEY_S_LO;
         3: return KEY_S_UP;
         4: return KEY_A_LO;
         5: return KEY_A_UP;
         6: return KEY_D_LO;
         default: return KEY_D_UP;
      endcase
   endfunction

   // Response side: random stalls, plus a long hold whenever one is asked for
   initial begin
      rsp_bus.ready = 1'b0;
      stall_left    = 0;
      hold_served   = 0;
      forever begin
         @(negedge clock);
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            stall_left  = LONG_HOLD;
         end
         if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready = 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   // Sample both channels and watch for a hang
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            sb.check_response(rsp_bus.linear_velocity, rsp_bus.angular_velocity);
         end
         if (req_bus.valid && req_bus.ready) begin
            sb.note_request(req_bus.func, req_bus.key_code);
         end
         if ((rsp_bus.valid && rsp_bus.ready) || (req_bus.valid && req_bus.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // Offer one request, hold it until taken, then idle for a random gap
   task automatic send_request(logic func, logic [KEY_W-1:0] key);
      @(negedge clock);
      req_bus.valid    = 1'b1;
      req_bus.func     = func;
      req_bus.key_code = key;
      do @(posedge clock); while (!req_bus.ready);
      repeat (pick_gap()) begin
         @(negedge clock);
         req_bus.valid    = 1'b0;
         req_bus.func     = 1'($urandom);
         req_bus.key_code = 8'($urandom);
      end
   endtask

   // Mostly motion keys between ticks, some space and stray keys
   task automatic send_random(int pct);
      int                roll;
      logic [KEY_W-1:0]  key;
      roll = $urandom_range(0, 99);
      key  = 8'($urandom);
      if (roll >= pct) send_request(FUNC_TICK, key);
      else if (roll < pct * 7 / 10) send_request(FUNC_KEY, motion_key());
      else if (roll < pct * 8 / 10) send_request(FUNC_KEY, KEY_SPACE);
      else send_request(FUNC_KEY, key);
   endtask

   // Drop valid and wait until every owed pair has come back
   task automatic settle();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (sb.commands_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] data);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index    = idx;
      csr_wdata    = data;
      sb.write_register(idx, data);
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   task automatic apply_settings(logic [CSR_DAT_W-1:0] lin, logic [CSR_DAT_W-1:0] ang,
                                 logic [CSR_DAT_W-1:0] lin_step,
                                 logic [CSR_DAT_W-1:0] ang_step,
                                 logic [CSR_DAT_W-1:0] timeout_raw);
      settle();
      write_csr(CSR_MAX_LINEAR, lin);
      write_csr(CSR_MAX_ANGULAR, ang);
      write_csr(CSR_LINEAR_STEP, lin_step);
      write_csr(CSR_ANGULAR_STEP, ang_step);
      write_csr(CSR_TIMEOUT_TICKS, timeout_raw);
      // Spare indexes must leave the limits alone
      for (int i = CSR_SPARE_FIRST; i < (1 << CSR_IDX_W); i++) begin
         write_csr(CSR_IDX_W'(i), CSR_DAT_W'($urandom));
      end
   endtask

   initial begin
      sb               = new();
      reset            = 1'b1;
      csr_write_en     = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req_bus.valid    = 1'b0;
      req_bus.func     = FUNC_TICK;
      req_bus.key_code = '0;
      gaps_on          = 1'b1;
      hold_requests    = 0;
      key_pct          = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part at the reset limits: ramps, timeout, stop, stray keys
      send_request(FUNC_KEY, KEY_W_LO);
      send_request(FUNC_TICK, 8'hFF);
      send_request(FUNC_TICK, 8'h00);
      send_request(FUNC_KEY, KEY_A_UP);
      repeat (5) send_request(FUNC_TICK, 8'($urandom));
      send_request(FUNC_KEY, KEY_S_UP);
      send_request(FUNC_KEY, KEY_D_LO);
      send_request(FUNC_TICK, KEY_W_LO);
      send_request(FUNC_TICK, KEY_SPACE);
      send_request(FUNC_KEY, KEY_SPACE);
      send_request(FUNC_TICK, 8'h00);
      send_request(FUNC_KEY, "q");
      send_request(FUNC_TICK, 8'h00);
      send_request(FUNC_KEY, 8'h00);
      send_request(FUNC_KEY, 8'hFF);
      send_request(FUNC_KEY, KEY_W_UP);
      send_request(FUNC_KEY, KEY_D_UP);
      send_request(FUNC_TICK, 8'h00);
      send_request(FUNC_KEY, KEY_S_LO);
      send_request(FUNC_KEY, KEY_A_LO);
      send_request(FUNC_TICK, 8'hFF);

      // Random phases, each under its own limits
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               apply_settings(MAX_LINEAR_RST, MAX_ANGULAR_RST, LINEAR_STEP_RST,
                              ANGULAR_STEP_RST, {7'h00, TIMEOUT_TICKS_RST});
               key_pct = 40;
            end
            1: begin
               apply_settings('1, '1, '1, '1, '1);
               key_pct = 50;
            end
            2: begin
               apply_settings('0, '0, '0, '0, {7'h7F, 8'h00});
               key_pct = 30;
            end
            3: begin
               apply_settings(CSR_DAT_W'($urandom_range(16000, 32767)),
                              CSR_DAT_W'($urandom_range(8000, 32767)), '0,
                              CSR_DAT_W'($urandom_range(1, 500)), 15'd5);
               key_pct = 45;
            end
            4: begin
               apply_settings(CSR_DAT_W'($urandom_range(0, 32767)),
                              CSR_DAT_W'($urandom_range(0, 32767)),
                              CSR_DAT_W'($urandom_range(1, 4000)),
                              CSR_DAT_W'($urandom_range(1, 4000)),
                              {7'($urandom), TICKS_W'($urandom_range(0, 12))});
               key_pct = 35;
            end
            5: begin
               apply_settings(CSR_DAT_W'($urandom_range(20000, 32767)),
                              CSR_DAT_W'($urandom_range(20000, 32767)),
                              CSR_DAT_W'($urandom_range(1, 800)), '0,
                              {7'($urandom), 8'h00});
               key_pct = 60;
            end
            default: begin
               apply_settings(CSR_DAT_W'($urandom_range(0, 300)),
                              CSR_DAT_W'($urandom_range(0, 300)),
                              CSR_DAT_W'($urandom), CSR_DAT_W'($urandom),
                              CSR_DAT_W'($urandom));
               key_pct = 15;
            end
         endcase
         // One phase runs with no idling on either side
         gaps_on = (phase != 1);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 4 && n == PHASE_ITEMS / 2) begin
               // Hold off the response side while ticks keep coming
               hold_requests++;
               gaps_on = 1'b0;
               repeat (PRESSURE_TICKS) send_request(FUNC_TICK, 8'($urandom));
               gaps_on = 1'b1;
            end
            send_random(key_pct);
         end
      end

      // Long run of ticks past counter saturation, timeout at its top value
      apply_settings(CSR_DAT_W'($urandom), CSR_DAT_W'($urandom),
                     CSR_DAT_W'($urandom_range(1, 200)), CSR_DAT_W'($urandom_range(1, 200)),
                     {7'($urandom), TICKS_SAT});
      send_request(FUNC_KEY, KEY_W_LO);
      send_request(FUNC_KEY, KEY_D_UP);
      repeat (SAT_TICKS) send_request(FUNC_TICK, 8'($urandom));
      send_request(FUNC_KEY, 8'($urandom));
      send_request(FUNC_TICK, 8'($urandom));

      settle();
      if (sb.failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
